// File: design/spq_pkg.sv
// Package for the sorted priority queue: command and status codes, field widths
// and the per-cycle control struct broadcast to the cells.
// No dependencies.
`default_nettype none

package spq_pkg;

   localparam int CMD_WIDTH    = 1;
   localparam int PORT_KEY_W   = 32;
   localparam int STATUS_WIDTH = 2;
   localparam int COUNT_WIDTH  = 5;

   localparam logic [CMD_WIDTH-1:0] CMD_ENQUEUE = 1'b0;
   localparam logic [CMD_WIDTH-1:0] CMD_DEQUEUE = 1'b1;

   localparam logic [STATUS_WIDTH-1:0] STATUS_DONE  = 2'd0;
   localparam logic [STATUS_WIDTH-1:0] STATUS_FULL  = 2'd1;
   localparam logic [STATUS_WIDTH-1:0] STATUS_EMPTY = 2'd2;

   // One operation that the whole row of cells carries out this cycle.
   typedef struct packed {
      logic enq;
      logic deq;
   } spq_ctrl_type;

endpackage

`default_nettype wire

// File: design/sorted_priority_queue_unit.sv
// Sorted priority queue, smallest key first, built as a row of DEPTH cells.
// An accepted item's result is registered and is shown in the next cycle;
// throughput one item per cycle when the output is not held, set by the single
// compare-and-shift step of the cell row. A result waits in the output register;
// a new item is taken when it is empty or being taken. Reset empties the queue
// (count to zero); keys are not cleared. Depends on spq_pkg and spq_cell.
`default_nettype none

module sorted_priority_queue_unit #(
   parameter int DEPTH     = 16,
   parameter int KEY_WIDTH = 32
) (
   input  wire                                    clock,
   input  wire                                    reset,
   input  wire                                    req_valid,
   output logic                                   req_ready,
   input  wire  [spq_pkg::CMD_WIDTH-1:0]          req_command,
   input  wire  [spq_pkg::PORT_KEY_W-1:0]         req_key_in,
   output logic                                   rsp_valid,
   input  wire                                    rsp_ready,
   output logic [spq_pkg::STATUS_WIDTH-1:0]       rsp_status,
   output logic [spq_pkg::PORT_KEY_W-1:0]         rsp_dequeued_key,
   output logic [spq_pkg::PORT_KEY_W-1:0]         rsp_head_key,
   output logic [spq_pkg::COUNT_WIDTH-1:0]        rsp_entry_count,
   output logic                                   rsp_empty_flag,
   output logic                                   rsp_full_flag
);

   localparam int CW = $clog2(DEPTH + 1);

   logic [CW-1:0]        count_ff;
   logic [CW-1:0]        count_in;
   spq_pkg::spq_ctrl_type ctrl;
   logic                 accept;
   logic                 is_full;
   logic                 no_keys;
   logic [KEY_WIDTH-1:0] new_key;

   logic [KEY_WIDTH-1:0] cell_key  [DEPTH];
   logic [KEY_WIDTH-1:0] cell_next [DEPTH];
   logic                 cell_lt   [DEPTH];

   logic                                rsp_valid_ff;
   logic                                rsp_valid_in;
   logic [spq_pkg::STATUS_WIDTH-1:0]    status_ff;
   logic [spq_pkg::STATUS_WIDTH-1:0]    status_in;
   logic [spq_pkg::PORT_KEY_W-1:0]      deq_key_ff;
   logic [spq_pkg::PORT_KEY_W-1:0]      deq_key_in;
   logic [spq_pkg::PORT_KEY_W-1:0]      head_ff;
   logic [spq_pkg::PORT_KEY_W-1:0]      head_in;
   logic [spq_pkg::COUNT_WIDTH-1:0]     cnt_out_ff;
   logic [spq_pkg::COUNT_WIDTH-1:0]     cnt_out_in;
   logic                                empty_ff;
   logic                                empty_in;
   logic                                full_ff;
   logic                                full_in;

   assign req_ready = !rsp_valid_ff || rsp_ready;
   assign accept    = req_valid && req_ready;
   assign is_full   = (count_ff == CW'(DEPTH));
   assign no_keys   = (count_ff == '0);
   assign new_key   = KEY_WIDTH'(req_key_in);

   always_comb begin
      ctrl.enq = accept && (req_command == spq_pkg::CMD_ENQUEUE) && !is_full;
      ctrl.deq = accept && (req_command == spq_pkg::CMD_DEQUEUE) && !no_keys;
   end

   genvar i;
   generate
      for (i = 0; i < DEPTH; i++) begin : g_cell
         logic [KEY_WIDTH-1:0] left_key;
         logic                 left_lt;
         logic [KEY_WIDTH-1:0] right_key;

         if (i == 0) begin : g_first
            assign left_key = new_key;
            assign left_lt  = 1'b1;
         end else begin : g_mid
            assign left_key = cell_key[i-1];
            assign left_lt  = cell_lt[i-1];
         end

         if (i == DEPTH - 1) begin : g_last
            assign right_key = cell_key[i];
         end else begin : g_inner
            assign right_key = cell_key[i+1];
         end

         spq_cell #(
            .KEY_WIDTH(KEY_WIDTH)
         ) u_cell (
            .clock    (clock),
            .ctrl     (ctrl),
            .new_key  (new_key),
            .valid    (CW'(i) < count_ff),
            .left_key (left_key),
            .left_lt  (left_lt),
            .right_key(right_key),
            .key_out  (cell_key[i]),
            .key_next (cell_next[i]),
            .lt_out   (cell_lt[i])
         );
      end
   endgenerate

   always_comb begin
      count_in = count_ff;
      if (ctrl.enq) begin
         count_in = count_ff + CW'(1);
      end else if (ctrl.deq) begin
         count_in = count_ff - CW'(1);
      end
   end

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (accept) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_comb begin
      status_in = spq_pkg::STATUS_DONE;
      if (req_command == spq_pkg::CMD_ENQUEUE && is_full) begin
         status_in = spq_pkg::STATUS_FULL;
      end else if (req_command == spq_pkg::CMD_DEQUEUE && no_keys) begin
         status_in = spq_pkg::STATUS_EMPTY;
      end
      deq_key_in = ctrl.deq ? spq_pkg::PORT_KEY_W'(cell_key[0]) : '0;
      head_in    = (count_in == '0) ? '0 : spq_pkg::PORT_KEY_W'(cell_next[0]);
      cnt_out_in = spq_pkg::COUNT_WIDTH'(count_in);
      empty_in   = (count_in == '0);
      full_in    = (count_in == CW'(DEPTH));
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         count_ff     <= count_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         status_ff  <= status_in;
         deq_key_ff <= deq_key_in;
         head_ff    <= head_in;
         cnt_out_ff <= cnt_out_in;
         empty_ff   <= empty_in;
         full_ff    <= full_in;
      end
   end

   assign rsp_valid        = rsp_valid_ff;
   assign rsp_status       = status_ff;
   assign rsp_dequeued_key = deq_key_ff;
   assign rsp_head_key     = head_ff;
   assign rsp_entry_count  = cnt_out_ff;
   assign rsp_empty_flag   = empty_ff;
   assign rsp_full_flag    = full_ff;

endmodule

`default_nettype wire

// File: design/spq_cell.sv
// One storage cell of the sorted key row: holds a key, compares it with the
// broadcast key and shifts toward either neighbor. Depends on spq_pkg.
`default_nettype none

module spq_cell #(
   parameter int KEY_WIDTH = 32
) (
   input  wire                       clock,
   input  spq_pkg::spq_ctrl_type     ctrl,
   input  wire  [KEY_WIDTH-1:0]      new_key,
   input  wire                       valid,
   input  wire  [KEY_WIDTH-1:0]      left_key,
   input  wire                       left_lt,
   input  wire  [KEY_WIDTH-1:0]      right_key,
   output logic [KEY_WIDTH-1:0]      key_out,
   output logic [KEY_WIDTH-1:0]      key_next,
   output logic                      lt_out
);

   logic [KEY_WIDTH-1:0] key_ff;
   logic [KEY_WIDTH-1:0] key_in;

   // Stored key strictly smaller than the new one: it stays ahead of it.
   assign lt_out = valid && (key_ff < new_key);

   always_comb begin
      key_in = key_ff;
      if (ctrl.enq) begin
         if (!lt_out) begin
            key_in = left_lt ? new_key : left_key;
         end
      end else if (ctrl.deq) begin
         key_in = right_key;
      end
   end

   always_ff @(posedge clock) begin
      key_ff <= key_in;
   end

   assign key_out  = key_ff;
   assign key_next = key_in;

endmodule

`default_nettype wire
